// File: design/rtt_pkg.sv
// Shared constants, types and helpers for the RGBA to tiled texture converter.
package rtt_pkg;

    localparam int unsigned MAX_WIDTH  = 1024;
    localparam int unsigned MAX_HEIGHT = 1024;

    localparam int DIM_W      = 11;                   // width of the size registers
    localparam int PIX_W      = 32;                   // A,R,G,B packed high to low
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int TCOL_W     = COL_W - 2;            // tile column
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int BAND_W     = ROW_W - 2;
    localparam int ADDR_W     = COL_W + 2;            // four rows of MAX_WIDTH words
    localparam int RAM_DEPTH  = 4 * MAX_WIDTH;
    localparam int TILE_WORDS = 32;
    localparam int K_W        = $clog2(TILE_WORDS);
    localparam int MAXD_W     = (COL_W > ROW_W) ? ((COL_W > DIM_W) ? COL_W : DIM_W)
                                                : ((ROW_W > DIM_W) ? ROW_W : DIM_W);
    localparam int CMP_W      = MAXD_W + 2;

    localparam logic CFG_IMG_WIDTH  = 1'b0;
    localparam logic CFG_IMG_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] RST_DIM = DIM_W'(256);

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  data;
    } t_wr;

    typedef struct packed {
        logic              start;
        logic              err;
        logic [TCOL_W-1:0] tcol;
        logic [BAND_W-1:0] band;
    } t_job;

    typedef struct packed {
        logic pad;
        logic half;
        logic last;
        logic err;
    } t_meta;

    // 0 counts as 1, values above the maximum count as the maximum
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int unsigned maxv);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (CMP_W'(v) > CMP_W'(maxv)) begin
            res = DIM_W'(maxv);
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// File: design/rtt_ram.sv
// Generic simple dual-port RAM with registered read.
module rtt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/rtt_ctrl.sv
// Command control: load counters, band state and emit job launch.
module rtt_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_cmd,
    input  logic [rtt_pkg::PIX_W-1:0]   i_pix,
    input  logic [rtt_pkg::DIM_W-1:0]   i_w,
    input  logic [rtt_pkg::DIM_W-1:0]   i_h,
    input  logic                        i_emit_busy,
    output rtt_pkg::t_wr                o_wr,
    output rtt_pkg::t_job               o_job
);
    import rtt_pkg::*;

    logic [COL_W-1:0]  r_col,  n_col;
    logic [1:0]        r_row,  n_row;
    logic [BAND_W-1:0] r_band, n_band;
    logic [TCOL_W-1:0] r_etc,  n_etc;
    logic              r_full, n_full;

    logic              push_acc;
    logic              emit_acc;
    logic [CMP_W-1:0]  w_ext;
    logic [CMP_W-1:0]  h_ext;
    logic [CMP_W-1:0]  col_inc;
    logic [2:0]        row_inc;
    logic [CMP_W-1:0]  top;
    logic [CMP_W-1:0]  etc_inc4;
    logic [CMP_W-1:0]  aligned_w;
    logic [CMP_W-1:0]  band_inc4;

    // input stalls while the emitter issues reads, so no read and write share a cycle
    assign o_in_ready = ~i_emit_busy;
    assign push_acc   = i_in_valid & o_in_ready & ~i_cmd;
    assign emit_acc   = i_in_valid & o_in_ready & i_cmd;

    assign w_ext     = CMP_W'(i_w);
    assign h_ext     = CMP_W'(i_h);
    assign col_inc   = CMP_W'(r_col) + CMP_W'(1);
    assign row_inc   = {1'b0, r_row} + 3'd1;
    assign top       = CMP_W'({r_band, 2'b00});
    assign etc_inc4  = (CMP_W'(r_etc) + CMP_W'(1)) << 2;
    assign aligned_w = (w_ext + CMP_W'(3)) & ~CMP_W'(3);
    assign band_inc4 = (CMP_W'(r_band) + CMP_W'(1)) << 2;

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_band = r_band;
        n_etc  = r_etc;
        n_full = r_full;

        o_wr.we   = push_acc & ~r_full;
        o_wr.addr = {r_row, r_col};
        o_wr.data = i_pix;

        o_job.start = emit_acc;
        o_job.err   = ~r_full;
        o_job.tcol  = r_etc;
        o_job.band  = r_band;

        if (o_wr.we) begin
            n_col = col_inc[COL_W-1:0];
            if (col_inc >= w_ext) begin
                n_col = '0;
                n_row = row_inc[1:0];
                // short last band counts as full at the image bottom
                if (row_inc[2] || (top + CMP_W'(row_inc) >= h_ext)) begin
                    n_full = 1'b1;
                end
            end
        end

        if (emit_acc && r_full) begin
            n_etc = r_etc + TCOL_W'(1);
            if (etc_inc4 >= aligned_w) begin
                n_etc  = '0;
                n_full = 1'b0;
                n_col  = '0;
                n_row  = '0;
                n_band = r_band + BAND_W'(1);
                if (band_inc4 >= h_ext) begin
                    n_band = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_band <= '0;
            r_etc  <= '0;
            r_full <= 1'b0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_band <= n_band;
            r_etc  <= n_etc;
            r_full <= n_full;
        end
    end

endmodule

// File: design/rtt_emit.sv
// Tile emitter: read sequencer over the band store and two-stage output pipeline.
module rtt_emit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rtt_pkg::t_job                i_job,
    input  logic [rtt_pkg::DIM_W-1:0]    i_w,
    input  logic [rtt_pkg::DIM_W-1:0]    i_h,
    output logic                         o_busy,
    output logic                         o_re,
    output logic [rtt_pkg::ADDR_W-1:0]   o_raddr,
    input  logic [rtt_pkg::PIX_W-1:0]    i_rdata,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [7:0]                   o_first,
    output logic [7:0]                   o_second,
    output logic                         o_half,
    output logic                         o_last,
    output logic                         o_err
);
    import rtt_pkg::*;

    logic              r_busy,     n_busy;
    logic [K_W-1:0]    r_k,        n_k;
    logic              r_err,      n_err;
    logic [TCOL_W-1:0] r_tcol,     n_tcol;
    logic [BAND_W-1:0] r_band,     n_band;
    logic              r_s1_valid, n_s1_valid;
    t_meta             r_s1_meta,  n_s1_meta;
    logic              r_o_valid,  n_o_valid;
    t_meta             r_o_meta,   n_o_meta;
    logic [7:0]        r_o_first,  n_o_first;
    logic [7:0]        r_o_second, n_o_second;

    logic              stall;
    logic              adv;
    logic              issue;
    logic              k_last;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    t_meta             meta_iss;

    assign stall  = r_o_valid & ~i_out_ready;
    assign adv    = ~stall;
    assign issue  = r_busy & adv;
    assign k_last = (r_k == K_W'(TILE_WORDS - 1));
    assign col    = {r_tcol, r_k[1:0]};
    assign row    = {r_band, r_k[3:2]};

    assign meta_iss.pad  = r_err || (CMP_W'(col) >= CMP_W'(i_w))
                                 || (CMP_W'(row) >= CMP_W'(i_h));
    assign meta_iss.half = r_k[K_W-1] & ~r_err;
    assign meta_iss.last = k_last | r_err;
    assign meta_iss.err  = r_err;

    // RAM output register holds while no read is issued, so stage 1 keeps its data
    assign o_re    = issue & ~r_err;
    assign o_raddr = {r_k[3:2], col};
    assign o_busy  = r_busy;

    always_comb begin
        n_busy     = r_busy;
        n_k        = r_k;
        n_err      = r_err;
        n_tcol     = r_tcol;
        n_band     = r_band;
        n_s1_valid = r_s1_valid;
        n_s1_meta  = r_s1_meta;
        n_o_valid  = r_o_valid;
        n_o_meta   = r_o_meta;
        n_o_first  = r_o_first;
        n_o_second = r_o_second;

        priority if (i_job.start) begin
            n_busy = 1'b1;
            n_k    = '0;
            n_err  = i_job.err;
            n_tcol = i_job.tcol;
            n_band = i_job.band;
        end else if (issue) begin
            n_k = r_k + K_W'(1);
            if (k_last || r_err) begin
                n_busy = 1'b0;
            end
        end

        if (adv) begin
            n_s1_valid = issue;
            n_s1_meta  = meta_iss;
            n_o_valid  = r_s1_valid;
            n_o_meta   = r_s1_meta;
            if (r_s1_meta.pad) begin
                n_o_first  = '0;
                n_o_second = '0;
            end else if (r_s1_meta.half) begin
                n_o_first  = i_rdata[15:8];
                n_o_second = i_rdata[7:0];
            end else begin
                n_o_first  = i_rdata[31:24];
                n_o_second = i_rdata[23:16];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_k        <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_busy     <= n_busy;
            r_k        <= n_k;
            r_s1_valid <= n_s1_valid;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_err      <= n_err;
        r_tcol     <= n_tcol;
        r_band     <= n_band;
        r_s1_meta  <= n_s1_meta;
        r_o_meta   <= n_o_meta;
        r_o_first  <= n_o_first;
        r_o_second <= n_o_second;
    end

    assign o_out_valid = r_o_valid;
    assign o_first     = r_o_first;
    assign o_second    = r_o_second;
    assign o_half      = r_o_meta.half;
    assign o_last      = r_o_meta.last;
    assign o_err       = r_o_meta.err;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job.start |-> !r_busy)
        else $error("emit job launched while sequencer busy");

    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_meta.err) |-> (r_o_meta.last && !r_o_meta.half
                                         && r_o_first == 8'd0 && r_o_second == 8'd0))
        else $error("error word malformed");

    a_busy_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && !r_err && !k_last) |=> r_busy)
        else $error("tile sequence ended early");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && stall) |=> r_s1_valid)
        else $error("stage 1 word lost under stall");

    a_no_read_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_re |-> (r_busy && !r_err))
        else $error("band store read outside a tile job");

endmodule

// File: design/rgba_to_tiled_texture.sv
// Top level: size registers, band store and the command/emit datapath.
// Push beat: written to the band store at the edge that accepts it, or dropped if the band is full; no output.
// Emit beat: input stalls while one band-store read per word is issued;
//   first word goes through stage 1 and the output register, then one word per cycle unless stalled.
// Error word (emit before the band is loaded): one word.
// Sustained: each pixel takes one push and gives two output words; input held during readout.
// Reset (synchronous, active low): counters clear, sizes go to 256x256; store is not cleared.
module rgba_to_tiled_texture (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [31:0]                s_axis_tdata,  // red, green, blue, alpha
    input  logic                       s_axis_tuser,  // cmd
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [15:0]                m_axis_tdata,  // first_byte, second_byte
    output logic [1:0]                 m_axis_tuser,  // gb_half, error
    output logic                       m_axis_tlast,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic                       i_cfg_index,
    input  logic [rtt_pkg::DIM_W-1:0]  i_cfg_data
);
    import rtt_pkg::*;

    logic [DIM_W-1:0]  r_img_width;
    logic [DIM_W-1:0]  r_img_height;
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [PIX_W-1:0]  pix;
    t_wr               wr;
    t_job              job;
    logic              emit_busy;
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic [PIX_W-1:0]  rdata;
    logic              o_half;
    logic              o_err;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_width  <= RST_DIM;
            r_img_height <= RST_DIM;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_IMG_WIDTH:  r_img_width  <= i_cfg_data;
                CFG_IMG_HEIGHT: r_img_height <= i_cfg_data;
                default:        r_img_width  <= r_img_width;
            endcase
        end
    end

    assign w = clamp_dim(r_img_width,  MAX_WIDTH);
    assign h = clamp_dim(r_img_height, MAX_HEIGHT);

    // store word: alpha, red, green, blue from high to low byte
    assign pix = {s_axis_tdata[31:24], s_axis_tdata[7:0],
                  s_axis_tdata[15:8],  s_axis_tdata[23:16]};

    rtt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_cmd       (s_axis_tuser),
        .i_pix       (pix),
        .i_w         (w),
        .i_h         (h),
        .i_emit_busy (emit_busy),
        .o_wr        (wr),
        .o_job       (job)
    );

    rtt_ram #(
        .WIDTH (PIX_W),
        .DEPTH (RAM_DEPTH)
    ) u_band_store (
        .i_clk   (i_clk),
        .i_we    (wr.we),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    rtt_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job),
        .i_w         (w),
        .i_h         (h),
        .o_busy      (emit_busy),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_first     (m_axis_tdata[7:0]),
        .o_second    (m_axis_tdata[15:8]),
        .o_half      (o_half),
        .o_last      (m_axis_tlast),
        .o_err       (o_err)
    );

    assign m_axis_tuser = {o_err, o_half};

endmodule

// File: bench/rtt_bench_pkg.sv
// Command codes shared by the tiled texture converter bench files.
`timescale 1ns / 1ps

package rtt_bench_pkg;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_EMIT = 1'b1
    } t_cmd;

endpackage

// File: bench/rtt_tile_checker.sv
// Tile checker: mirrors the band store and tile walk, compares every output beat.
`timescale 1ns / 1ps

module rtt_tile_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    input  logic [31:0]               s_axis_tdata,   // red, green, blue, alpha
    input  logic                      s_axis_tuser,   // cmd
    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    input  logic [15:0]               m_axis_tdata,   // first_byte, second_byte
    input  logic [1:0]                m_axis_tuser,   // gb_half, error
    input  logic                      m_axis_tlast,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic                      i_cfg_index,
    input  logic [rtt_pkg::DIM_W-1:0] i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);

    import rtt_pkg::*;
    import rtt_bench_pkg::*;

    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       gb_half;
        logic       last;
        logic       err;
    } t_tile_word;

    t_tile_word        tile_words[$];
    logic [PIX_W-1:0]  band_store [RAM_DEPTH];

    logic [DIM_W-1:0]  img_width;
    logic [DIM_W-1:0]  img_height;
    logic [DIM_W-1:0]  load_column;
    logic [2:0]        load_row;
    logic [BAND_W-1:0] band_index;
    logic [TCOL_W-1:0] tile_column;
    logic              band_full;

    function automatic int unsigned dim_limit(input logic [DIM_W-1:0] v,
                                              input int unsigned maxv);
        if (v == '0) return 1;
        if (int'(v) > maxv) return maxv;
        return int'(v);
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    // Advance the mirrored converter by one accepted input beat.
    task automatic convert_beat(input logic cmd, input logic [31:0] data);
        int unsigned w, h, band_top, bx, aligned_w, col, k, half, y, x;
        logic [PIX_W-1:0] px;
        t_tile_word word;
        w = dim_limit(img_width, MAX_WIDTH);
        h = dim_limit(img_height, MAX_HEIGHT);
        band_top = int'(band_index) * 4;
        if (cmd == CMD_PUSH) begin
            if (!band_full) begin
                if (load_row < 4 && load_column < MAX_WIDTH)
                    band_store[int'(load_row) * MAX_WIDTH + int'(load_column)] =
                        {data[31:24], data[7:0], data[15:8], data[23:16]};
                // counter may already sit past a shrunken width; it wraps here
                if (int'(load_column) + 1 >= w) begin
                    load_column = '0;
                    load_row++;
                    if (load_row >= 4 || band_top + int'(load_row) >= h)
                        band_full = 1'b1;
                end else begin
                    load_column++;
                end
            end
        end else if (!band_full) begin
            word = '{first_byte: 8'd0, second_byte: 8'd0, gb_half: 1'b0,
                     last: 1'b1, err: 1'b1};
            tile_words.push_back(word);
        end else begin
            bx = int'(tile_column) * 4;
            aligned_w = (w + 3) & ~3;
            k = 0;
            for (half = 0; half < 2; half++) begin
                for (y = 0; y < 4; y++) begin
                    for (x = 0; x < 4; x++) begin
                        col = bx + x;
                        px = '0;
                        if (col < w && band_top + y < h && col < MAX_WIDTH)
                            px = band_store[y * MAX_WIDTH + col];
                        word.first_byte  = half[0] ? px[15:8] : px[31:24];
                        word.second_byte = half[0] ? px[7:0]  : px[23:16];
                        word.gb_half     = half[0];
                        word.last        = (k == TILE_WORDS - 1);
                        word.err         = 1'b0;
                        tile_words.push_back(word);
                        k++;
                    end
                end
            end
            if ((int'(tile_column) + 1) * 4 >= aligned_w) begin
                tile_column = '0;
                band_full   = 1'b0;
                load_column = '0;
                load_row    = '0;
                if ((int'(band_index) + 1) * 4 >= h) band_index = '0;
                else band_index++;
            end else begin
                tile_column++;
            end
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_tile_word want;
        if (!i_rst_n) begin
            img_width   = RST_DIM;
            img_height  = RST_DIM;
            load_column = '0;
            load_row    = '0;
            band_index  = '0;
            tile_column = '0;
            band_full   = 1'b0;
            tile_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_IMG_WIDTH) img_width = i_cfg_data;
                else img_height = i_cfg_data;
            end
            // output beats stem from older inputs, so check before predicting
            if (m_axis_tvalid && m_axis_tready) begin
                if (tile_words.size() == 0) begin
                    $error("output beat with no word expected");
                    o_fail_count++;
                end else begin
                    want = tile_words.pop_front();
                    check_field("first_byte", int'(want.first_byte),
                                int'(m_axis_tdata[7:0]));
                    check_field("second_byte", int'(want.second_byte),
                                int'(m_axis_tdata[15:8]));
                    check_field("gb_half", int'(want.gb_half), int'(m_axis_tuser[0]));
                    check_field("last", int'(want.last), int'(m_axis_tlast));
                    check_field("error", int'(want.err), int'(m_axis_tuser[1]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                convert_beat(s_axis_tuser, s_axis_tdata);
        end
        o_pending = tile_words.size();
    end

endmodule

// File: bench/rgba_to_tiled_texture_test.sv
// Top of the tiled texture converter bench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module rgba_to_tiled_texture_test;

    import rtt_pkg::*;
    import rtt_bench_pkg::*;

    localparam int RANDOM_BEATS   = 80;
    localparam int SETTLE_CYCLES  = 8;
    localparam int END_CYCLES     = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_RANDOM,
        RX_SPARSE
    } t_rx_mode;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata  = '0;
    logic              s_axis_tuser  = CMD_PUSH;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [15:0]       m_axis_tdata;
    logic [1:0]        m_axis_tuser;
    logic              m_axis_tlast;
    logic              i_cfg_valid   = 1'b0;
    logic              o_cfg_ready;
    logic              i_cfg_index   = CFG_IMG_WIDTH;
    logic [DIM_W-1:0]  i_cfg_data    = '0;

    int                fail_count;
    int                pending_words;
    int                beats_sent    = 0;
    int                burst_left    = 0;
    t_rx_mode          rx_mode       = RX_STEADY;
    int                rx_cycles     = 0;

    rgba_to_tiled_texture dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    rtt_tile_checker tile_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending_words)
    );

    always #5 i_clk = ~i_clk;

    // receiver: switches between steady, random and sparse acceptance
    always @(negedge i_clk) begin
        if (rx_cycles == 0) begin
            rx_mode   <= t_rx_mode'($urandom_range(0, 2));
            rx_cycles <= $urandom_range(20, 80);
        end else begin
            rx_cycles <= rx_cycles - 1;
        end
        case (rx_mode)
            RX_STEADY: m_axis_tready <= 1'b1;
            RX_RANDOM: m_axis_tready <= ($urandom_range(0, 2) != 0);
            default:   m_axis_tready <= (rx_cycles % 6 == 0);
        endcase
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // One input beat; the sender runs in bursts with idle gaps between most of them.
    task automatic send_beat(input t_cmd cmd, input logic [31:0] data, input bit counted);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = data;
        s_axis_tuser  = cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        if (counted) beats_sent++;
    endtask

    task automatic push_pixel(input logic [7:0] r, g, b, a, input bit counted);
        send_beat(CMD_PUSH, {a, b, g, r}, counted);
    endtask

    task automatic push_random(input bit counted);
        push_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte(), counted);
    endtask

    task automatic emit_tile();
        send_beat(CMD_EMIT, $urandom, 1'b1);
    endtask

    // Hold the sender until all words are out, then let the pipe settle.
    task automatic wait_idle(input int settle);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_words != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [DIM_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_size(input int w, input int h);
        wait_idle(SETTLE_CYCLES);
        write_reg(CFG_IMG_WIDTH, DIM_W'(w));
        write_reg(CFG_IMG_HEIGHT, DIM_W'(h));
    endtask

    // A whole small image: band loads with early emits mixed in, then its tiles.
    task automatic run_image();
        int w, h, band_top, rows;
        w = $urandom_range(1, 9);
        h = $urandom_range(1, 9);
        set_size(w, h);
        for (band_top = 0; band_top < h; band_top += 4) begin
            rows = (h - band_top < 4) ? h - band_top : 4;
            repeat (rows * w) begin
                if ($urandom_range(0, 29) == 0) wait_idle(0);
                if ($urandom_range(0, 9) == 0) emit_tile();
                push_random(1'b1);
            end
            repeat ((w + 3) / 4) begin
                if ($urandom_range(0, 5) == 0) push_random(1'b0);   // band full: dropped
                emit_tile();
            end
        end
    endtask

    initial begin : watchdog
        int quiet;
        quiet = 0;
        wait (i_rst_n);
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int base;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // nothing loaded after reset: error word
        emit_tile();

        // zero sizes count as 1x1; second push lands in a full band
        set_size(0, 0);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        push_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        emit_tile();

        // maximum sizes, then shrink width while the column counter is past it
        set_size(1024, 2047);
        push_pixel(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1);
        push_pixel(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1);
        push_random(1'b1);
        emit_tile();
        wait_idle(SETTLE_CYCLES);
        write_reg(CFG_IMG_WIDTH, DIM_W'(2));
        repeat (7) push_random(1'b1);
        emit_tile();

        // shrink height so the second band lies below the image: all padding
        wait_idle(SETTLE_CYCLES);
        write_reg(CFG_IMG_HEIGHT, DIM_W'(4));
        repeat (2) push_random(1'b1);
        emit_tile();

        base = beats_sent;
        while (beats_sent - base < RANDOM_BEATS) run_image();

        wait_idle(END_CYCLES);
        if (fail_count == 0 && pending_words == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
